// ===== src/lvp_pkg.sv =====
`default_nettype none
package lvp_pkg;

	// default bounds
	localparam longint unsigned MAX_LEN_DEF     = 64'd65536;
	localparam int unsigned     STACK_DEPTH_DEF = 1024;

	// character codes
	localparam logic [7:0] SYM_OPEN  = 8'h28;
	localparam logic [7:0] SYM_CLOSE = 8'h29;

	// reported span width and its saturation value
	localparam int unsigned      SPAN_W   = 17;
	localparam logic [SPAN_W-1:0] SPAN_MAX = '1;

	// command handed along the stack chain
	typedef struct packed {
		logic push;   // shift towards the bottom, top takes new data
		logic pop;    // shift towards the top
		logic load;   // top entry takes new data, rest hold
	} lvp_cmd_t;

endpackage
`default_nettype wire

// ===== src/lvp_if.sv =====
`default_nettype none
interface lvp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       end_of_string;

	modport source (output valid, symbol, end_of_string, input ready);
	modport sink (input valid, symbol, end_of_string, output ready);
endinterface

interface lvp_span_if;
	logic        valid;
	logic        ready;
	logic [16:0] longest_span;
	logic        overflowed;
	logic        final_result;

	modport source (output valid, longest_span, overflowed, final_result, input ready);
	modport sink (input valid, longest_span, overflowed, final_result, output ready);
endinterface
`default_nettype wire

// ===== src/lvp_cell.sv =====
`default_nettype none
module lvp_cell
	import lvp_pkg::*;
#(
	parameter int unsigned W = 17
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire lvp_cmd_t     cmd,
	input  wire logic [W-1:0] from_prev,
	input  wire logic [W-1:0] from_next,
	output logic      [W-1:0] value
);

	logic [W-1:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
		end else if (cmd.load || cmd.push) begin
			value_q <= from_prev;
		end else if (cmd.pop) begin
			value_q <= from_next;
		end
	end

	assign value = value_q;

endmodule
`default_nettype wire

// ===== src/lvp_stack.sv =====
`default_nettype none
module lvp_stack
	import lvp_pkg::*;
#(
	parameter int unsigned DEPTH = STACK_DEPTH_DEF,
	parameter int unsigned W     = 17
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire lvp_cmd_t     cmd,
	input  wire logic [W-1:0] data,
	output logic      [W-1:0] below_top
);

	logic [W-1:0] val [DEPTH];
	lvp_cmd_t     rest_cmd;

	// load only touches the top cell
	always_comb begin
		rest_cmd      = cmd;
		rest_cmd.load = 1'b0;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [W-1:0] prev_v;
		logic [W-1:0] next_v;
		if (i == 0) begin : g_top
			assign prev_v = data;
		end else begin : g_mid
			assign prev_v = val[i-1];
		end
		if (i == DEPTH - 1) begin : g_bot
			assign next_v = '0;
		end else begin : g_up
			assign next_v = val[i+1];
		end
		lvp_cell #(.W(W)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      ((i == 0) ? cmd : rest_cmd),
			.from_prev(prev_v),
			.from_next(next_v),
			.value    (val[i])
		);
	end

	assign below_top = val[1];

endmodule
`default_nettype wire

// ===== src/longest_valid_paren_stream.sv =====
`default_nettype none
// Longest well-formed parenthesis run over a character stream. One character
// request is taken per clock and each gives exactly one result: the longest
// well-formed run so far, a sticky overflow flag and a mark on the last
// character. The block sustains one character per cycle: the position stack
// is a chain of STACK_DEPTH cells that shifts as a whole on push and pop, so
// the top and the entry below it always sit in fixed cells and the span is a
// single subtract and compare. Results are registered and appear in the cycle
// after their character is taken; a held-up result blocks the next character,
// which is taken in the same cycle as the waiting result leaves. The stack
// holds positions plus one above a sentinel, zero at a string's start and
// later the position of the last unmatched close. A push into a full stack is
// dropped and a character past MAX_LEN is ignored; both raise the overflow flag.
// The last character clears the string state and reloads the top cell with zero.
module longest_valid_paren_stream
	import lvp_pkg::*;
#(
	parameter longint unsigned MAX_LEN     = MAX_LEN_DEF,
	parameter int unsigned     STACK_DEPTH = STACK_DEPTH_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	lvp_char_if.sink    chars,
	lvp_span_if.source  spans
);

	localparam int unsigned POS_W = $clog2(MAX_LEN + 1);
	localparam int unsigned SP_W  = $clog2(STACK_DEPTH + 1);
	localparam int unsigned EXT_W = (POS_W > SPAN_W) ? POS_W : SPAN_W;

	// string state
	logic [SP_W-1:0]  sp_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] best_q;
	logic             ovf_q;

	// result register
	logic              out_valid_q;
	logic [SPAN_W-1:0] out_span_q;
	logic              out_ovf_q;
	logic              out_final_q;

	logic             accept;
	logic             too_long;
	logic             is_open;
	logic             is_close;
	logic             full;
	logic             sentinel_only;
	logic [POS_W-1:0] here;
	logic [POS_W-1:0] below_top;
	logic [POS_W-1:0] span;
	logic [POS_W-1:0] best_n;
	logic             ovf_n;
	logic [SP_W-1:0]  sp_n;
	logic [POS_W-1:0] pos_n;
	logic [EXT_W-1:0] best_ext;
	logic [SPAN_W-1:0] span_sat;
	lvp_cmd_t         cmd;
	logic [POS_W-1:0] push_data;

	// free to take a request unless a result is stuck
	assign chars.ready = !out_valid_q || spans.ready;
	assign accept      = chars.valid && chars.ready;

	assign too_long      = (pos_q >= POS_W'(MAX_LEN));
	assign is_open       = (chars.symbol == SYM_OPEN);
	assign is_close      = (chars.symbol == SYM_CLOSE);
	assign full          = (sp_q == SP_W'(STACK_DEPTH));
	assign sentinel_only = (sp_q == SP_W'(1));
	assign here          = pos_q + POS_W'(1);

	always_comb begin
		cmd       = '0;
		push_data = here;
		span      = '0;
		sp_n      = sp_q;
		pos_n     = pos_q;
		ovf_n     = ovf_q;
		if (too_long) begin
			ovf_n = 1'b1;
		end else begin
			pos_n = here;
			if (is_open) begin
				if (full) begin
					ovf_n = 1'b1;
				end else begin
					cmd.push = 1'b1;
					sp_n     = sp_q + SP_W'(1);
				end
			end else if (is_close) begin
				if (sentinel_only) begin
					// stack empties: this close becomes the new base, span zero
					cmd.load = 1'b1;
				end else begin
					cmd.pop = 1'b1;
					sp_n    = sp_q - SP_W'(1);
					span    = (here >= below_top) ? (here - below_top) : '0;
				end
			end
		end
		best_n = (span > best_q) ? span : best_q;
		if (!accept) begin
			cmd = '0;
		end else if (chars.end_of_string) begin
			// back to the sentinel for the next string
			cmd       = '0;
			cmd.load  = 1'b1;
			push_data = '0;
		end
	end

	assign best_ext = EXT_W'(best_n);
	assign span_sat = (best_ext > EXT_W'(SPAN_MAX)) ? SPAN_MAX : SPAN_W'(best_ext);

	lvp_stack #(
		.DEPTH(STACK_DEPTH),
		.W    (POS_W)
	) u_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.data     (push_data),
		.below_top(below_top)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q   <= SP_W'(1);
			pos_q  <= '0;
			best_q <= '0;
			ovf_q  <= 1'b0;
		end else if (accept) begin
			if (chars.end_of_string) begin
				sp_q   <= SP_W'(1);
				pos_q  <= '0;
				best_q <= '0;
				ovf_q  <= 1'b0;
			end else begin
				sp_q   <= sp_n;
				pos_q  <= pos_n;
				best_q <= best_n;
				ovf_q  <= ovf_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (spans.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_span_q  <= span_sat;
			out_ovf_q   <= ovf_n;
			out_final_q <= chars.end_of_string;
		end
	end

	assign spans.valid        = out_valid_q;
	assign spans.longest_span = out_span_q;
	assign spans.overflowed   = out_ovf_q;
	assign spans.final_result = out_final_q;

	// stack pointer always covers at least the base entry and never more than the chain
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		(sp_q != '0) && (sp_q <= SP_W'(STACK_DEPTH)))
		else $error("stack pointer out of range");

	// a run can never be longer than the characters seen
	a_best_bound: assert property (@(posedge clk) disable iff (!arst_n)
		best_q <= pos_q)
		else $error("best length exceeds position");

	// the last character leaves the string state cleared
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && chars.end_of_string) |=>
		(sp_q == SP_W'(1)) && (pos_q == '0) && (best_q == '0) && !ovf_q)
		else $error("state not cleared after end of string");

	// a stalled result is not overwritten
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !spans.ready) |-> !accept)
		else $error("request taken over a pending result");

endmodule
`default_nettype wire

// ===== verif/longest_valid_paren_stream_test.sv =====
`timescale 1ns / 1ps

module longest_valid_paren_stream_test
	import lvp_pkg::*;
();

	// run bounds
	localparam int unsigned CYCLE_LIMIT = 2000000;
	localparam int unsigned RAND_CHARS  = 200;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned DRAIN_WAIT  = 16;
	localparam int unsigned REPORT_MAX  = 10;
	localparam int unsigned DIR_ROWS_N  = 23;

	// one result as it leaves the block
	typedef struct packed {
		logic [SPAN_W-1:0] longest_span;
		logic              overflowed;
		logic              final_result;
	} span_res_t;

	// one row of the directed table; span and ovf only count when typed is set
	typedef struct packed {
		logic [7:0]        sym;
		logic              eos;
		logic              typed;
		logic [SPAN_W-1:0] span;
		logic              ovf;
	} dir_row_t;

	// receiver stall patterns
	typedef enum int unsigned {SINK_OPEN, SINK_HALF, SINK_SLOW, SINK_PERIODIC} sink_mode_t;

	// kinds of random string
	typedef enum int unsigned {STR_BALANCED, STR_MIXED, STR_NOISE, STR_BROKEN} str_kind_t;

	// directed part: extremes of the byte, near-miss codes, lone brackets with the
	// end mark, nesting, non-bracket bytes inside a run
	localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
		'{SYM_OPEN,  1'b0, 1'b1, 17'd0, 1'b0},  // open straight after reset
		'{SYM_CLOSE, 1'b0, 1'b1, 17'd2, 1'b0},  // first pair
		'{SYM_CLOSE, 1'b0, 1'b0, 17'd0, 1'b0},  // unmatched close empties the stack
		'{SYM_OPEN,  1'b0, 1'b0, 17'd0, 1'b0},
		'{8'h61,     1'b0, 1'b0, 17'd0, 1'b0},  // plain letter only moves the position
		'{SYM_CLOSE, 1'b0, 1'b0, 17'd0, 1'b0},
		'{8'h00,     1'b1, 1'b0, 17'd0, 1'b0},  // lowest byte ends the string
		'{8'hFF,     1'b1, 1'b1, 17'd0, 1'b0},  // highest byte as a one-character string
		'{SYM_OPEN,  1'b1, 1'b1, 17'd0, 1'b0},  // lone open
		'{SYM_CLOSE, 1'b1, 1'b1, 17'd0, 1'b0},  // lone close
		'{SYM_OPEN,  1'b0, 1'b1, 17'd0, 1'b0},  // nested pair
		'{SYM_OPEN,  1'b0, 1'b1, 17'd0, 1'b0},
		'{SYM_CLOSE, 1'b0, 1'b1, 17'd2, 1'b0},
		'{SYM_CLOSE, 1'b1, 1'b1, 17'd4, 1'b0},
		'{8'h27,     1'b0, 1'b1, 17'd0, 1'b0},  // codes either side of the brackets
		'{8'h2A,     1'b0, 1'b1, 17'd0, 1'b0},
		'{SYM_CLOSE, 1'b0, 1'b1, 17'd0, 1'b0},
		'{SYM_OPEN,  1'b0, 1'b0, 17'd0, 1'b0},
		'{SYM_CLOSE, 1'b0, 1'b0, 17'd0, 1'b0},
		'{8'hA9,     1'b0, 1'b0, 17'd0, 1'b0},  // close with the top bit set is not a close
		'{8'h08,     1'b0, 1'b0, 17'd0, 1'b0},  // open with bit five cleared is not an open
		'{8'h69,     1'b0, 1'b0, 17'd0, 1'b0},
		'{SYM_CLOSE, 1'b1, 1'b0, 17'd0, 1'b0}
	};

	logic clk = 1'b0;
	logic arst_n;

	lvp_char_if chars_if ();
	lvp_span_if spans_if ();

	longest_valid_paren_stream dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.spans  (spans_if)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// predictor: own copy of the position stack and the counters
	// ------------------------------------------------------------------
	logic [SPAN_W-1:0] pos_stack [STACK_DEPTH_DEF];  // positions plus one
	logic [10:0]       stk_ptr;                      // entries in use, sentinel included
	logic [16:0]       char_idx;                     // index of the next character
	logic [SPAN_W-1:0] best_len;
	logic              ovf_flag;

	function automatic void clear_paren_state();
		foreach (pos_stack[i])
			pos_stack[i] = '0;
		stk_ptr  = 11'd1;
		char_idx = '0;
		best_len = '0;
		ovf_flag = 1'b0;
	endfunction

	// a push into a full stack is lost and marks the run as unreliable
	function automatic void stack_push(input logic [SPAN_W-1:0] v);
		if (stk_ptr >= STACK_DEPTH_DEF) begin
			ovf_flag = 1'b1;
		end else begin
			pos_stack[stk_ptr] = v;
			stk_ptr++;
		end
	endfunction

	function automatic span_res_t next_span(input logic [7:0] sym, input logic eos);
		span_res_t         r;
		logic [SPAN_W-1:0] here;
		logic [SPAN_W-1:0] top;
		logic [SPAN_W-1:0] span;
		if (char_idx >= MAX_LEN_DEF) begin
			// past the length bound: flag only, position stays put
			ovf_flag = 1'b1;
		end else begin
			here = char_idx + 17'd1;
			if (sym == SYM_OPEN) begin
				stack_push(here);
			end else if (sym == SYM_CLOSE) begin
				if (stk_ptr > 0)
					stk_ptr--;
				if (stk_ptr == 0)
					stack_push(here);
				if (stk_ptr > 0) begin
					top  = pos_stack[stk_ptr - 11'd1];
					span = (here >= top) ? here - top : '0;
					if (span > best_len)
						best_len = span;
				end
			end
			char_idx++;
		end
		// best length never exceeds the bound, so it always fits the span width
		r.longest_span = best_len;
		r.overflowed   = ovf_flag;
		r.final_result = eos;
		if (eos)
			clear_paren_state();
		return r;
	endfunction

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------
	span_res_t   span_expect_q [$];
	logic        offer_typed;      // current request carries a typed expectation
	span_res_t   offer_typed_res;
	int unsigned mismatches    = 0;
	int unsigned chars_taken   = 0;
	int unsigned spans_checked = 0;
	int unsigned ovf_results   = 0;
	logic [SPAN_W-1:0] widest_span = '0;

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("mismatch: %s", msg);
	endtask

	// input and output handshakes in one place: the expectation for a request
	// is queued before any result of the same edge is compared
	always @(posedge clk) begin : span_check
		span_res_t pred;
		span_res_t want;
		span_res_t got;
		if (!arst_n)
			clear_paren_state();
		if (arst_n && chars_if.valid && chars_if.ready) begin
			pred = next_span(chars_if.symbol, chars_if.end_of_string);
			span_expect_q.push_back(offer_typed ? offer_typed_res : pred);
			chars_taken++;
		end
		if (arst_n && spans_if.valid && spans_if.ready) begin
			got.longest_span = spans_if.longest_span;
			got.overflowed   = spans_if.overflowed;
			got.final_result = spans_if.final_result;
			spans_checked++;
			if (got.overflowed === 1'b1)
				ovf_results++;
			if (got.longest_span > widest_span)
				widest_span = got.longest_span;
			if (span_expect_q.size() == 0) begin
				report_mismatch($sformatf("result span=%0d ovf=%b last=%b with none pending",
					got.longest_span, got.overflowed, got.final_result));
			end else begin
				want = span_expect_q.pop_front();
				if (got.longest_span !== want.longest_span ||
				    got.overflowed !== want.overflowed ||
				    got.final_result !== want.final_result)
					report_mismatch($sformatf(
						"result %0d: expected span=%0d ovf=%b last=%b, got span=%0d ovf=%b last=%b",
						spans_checked, want.longest_span, want.overflowed, want.final_result,
						got.longest_span, got.overflowed, got.final_result));
			end
		end
	end

	// watchdog
	int unsigned cycle_cnt = 0;
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("longest_valid_paren_stream test failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// receiver: stalls in windows of changing pattern, plus one long hold-off
	// ------------------------------------------------------------------
	logic        hold_off_req;
	int unsigned hold_cnt;

	initial begin : span_sink
		sink_mode_t  mode;
		int unsigned window;
		int unsigned period;
		int unsigned n;
		spans_if.ready = 1'b0;
		hold_cnt       = 0;
		forever begin
			mode   = sink_mode_t'($urandom_range(0, 3));
			window = $urandom_range(16, 128);
			period = $urandom_range(2, 5);
			for (n = 0; n < window; n++) begin
				@(negedge clk);
				if (hold_off_req && hold_cnt < HOLD_CYCLES) begin
					// block stays busy with its output stuck, input must back up
					spans_if.ready <= 1'b0;
					hold_cnt++;
				end else begin
					case (mode)
						SINK_OPEN:     spans_if.ready <= 1'b1;
						SINK_HALF:     spans_if.ready <= 1'($urandom_range(0, 1));
						SINK_SLOW:     spans_if.ready <= ($urandom_range(0, 3) == 0);
						SINK_PERIODIC: spans_if.ready <= ((n % period) != 0);
						default:       spans_if.ready <= 1'b1;
					endcase
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// sender: bursts of requests with random gaps between them
	// ------------------------------------------------------------------
	int unsigned burst_left;
	logic [7:0]  str_q [$];
	int unsigned strings_sent;

	task automatic offer_char(input logic [7:0] sym, input logic eos,
	                          input logic typed, input span_res_t typed_res);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				chars_if.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		chars_if.valid         <= 1'b1;
		chars_if.symbol        <= sym;
		chars_if.end_of_string <= eos;
		offer_typed     = typed;
		offer_typed_res = typed_res;
		do @(posedge clk); while (!chars_if.ready);
	endtask

	// send the queued string, end mark on its last character
	task automatic send_string();
		for (int i = 0; i < str_q.size(); i++)
			offer_char(str_q[i], i == str_q.size() - 1, 1'b0, '0);
		str_q.delete();
		strings_sent++;
	endtask

	// well-formed run with the odd stray byte inside
	task automatic build_balanced(input int unsigned len);
		int unsigned depth;
		depth = 0;
		repeat (len) begin
			if ($urandom_range(0, 7) == 0) begin
				str_q.push_back(8'($urandom_range(0, 255)));
			end else if (depth == 0 || $urandom_range(0, 1)) begin
				str_q.push_back(SYM_OPEN);
				depth++;
			end else begin
				str_q.push_back(SYM_CLOSE);
				depth--;
			end
		end
		while (depth > 0) begin
			str_q.push_back(SYM_CLOSE);
			depth--;
		end
	endtask

	task automatic build_random_string(output int unsigned len);
		str_kind_t   kind;
		int unsigned pick;
		int unsigned n;
		pick = $urandom_range(0, 99);
		n    = $urandom_range(1, 48);
		if (pick < 60)      kind = STR_BALANCED;
		else if (pick < 75) kind = STR_MIXED;
		else if (pick < 90) kind = STR_NOISE;
		else                kind = STR_BROKEN;
		case (kind)
			STR_BALANCED: build_balanced(n);
			STR_MIXED:
				repeat (n) str_q.push_back($urandom_range(0, 1) ? SYM_OPEN : SYM_CLOSE);
			STR_NOISE:
				repeat (n) str_q.push_back(8'($urandom_range(0, 255)));
			STR_BROKEN: begin
				build_balanced(n);
				// cut one character off or hang a stray bracket on somewhere
				case ($urandom_range(0, 2))
					0: if (str_q.size() > 1) void'(str_q.pop_back());
					1: str_q.insert($urandom_range(0, str_q.size()), SYM_CLOSE);
					default: str_q.insert($urandom_range(0, str_q.size()), SYM_OPEN);
				endcase
			end
			default: build_balanced(n);
		endcase
		len = str_q.size();
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		span_res_t   typed_res;
		int unsigned rand_chars;
		int unsigned len;
		int unsigned str_no;
		arst_n                 = 1'b0;
		chars_if.valid         = 1'b0;
		chars_if.symbol        = '0;
		chars_if.end_of_string = 1'b0;
		offer_typed            = 1'b0;
		offer_typed_res        = '0;
		hold_off_req           = 1'b0;
		burst_left             = 0;
		strings_sent           = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		foreach (DIR_ROWS[i]) begin
			typed_res.longest_span = DIR_ROWS[i].span;
			typed_res.overflowed   = DIR_ROWS[i].ovf;
			typed_res.final_result = DIR_ROWS[i].eos;
			offer_char(DIR_ROWS[i].sym, DIR_ROWS[i].eos, DIR_ROWS[i].typed, typed_res);
		end

		// random strings; the receiver holds off at the start so the block backs up
		hold_off_req = 1'b1;
		rand_chars   = 0;
		str_no       = 0;
		while (rand_chars < RAND_CHARS) begin
			str_no++;
			if (str_no == 2) begin
				// stack filled to the last entry, one pop and push back to full,
				// then pushes past the depth are dropped and flagged
				repeat (STACK_DEPTH_DEF - 1) str_q.push_back(SYM_OPEN);
				str_q.push_back(SYM_CLOSE);
				str_q.push_back(SYM_OPEN);
				repeat (3) str_q.push_back(SYM_OPEN);
				repeat (8) str_q.push_back(SYM_CLOSE);
				send_string();
			end else begin
				build_random_string(len);
				rand_chars += len;
				send_string();
			end
		end

		@(negedge clk);
		chars_if.valid <= 1'b0;

		// drain, then keep watching while idle to catch anything extra
		while (span_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("covered %0d strings, %0d characters, %0d results checked",
			strings_sent, chars_taken, spans_checked);
		$display("overflow flagged on %0d results, widest span %0d, %0d mismatches",
			ovf_results, widest_span, mismatches);
		if (mismatches == 0 && span_expect_q.size() == 0) begin
			$display("longest_valid_paren_stream test passed");
		end else begin
			$display("longest_valid_paren_stream test failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/lvp_pkg.sv
src/lvp_if.sv
src/lvp_cell.sv
src/lvp_stack.sv
src/longest_valid_paren_stream.sv
verif/longest_valid_paren_stream_test.sv
